// ===== hdl/c2c_pkg.sv =====
// shared types, codes and constants of the coo to csr converter
package c2c_pkg;

  localparam int unsigned MaxRowsDef    = 1024;
  localparam int unsigned MaxEntriesDef = 4096;
  localparam int unsigned RowW          = 11;
  localparam int unsigned ColW          = 16;
  localparam int unsigned ValW          = 32;
  localparam int unsigned IdxW          = 13;
  localparam int unsigned CfgDataW      = 16;
  localparam logic [ValW-1:0] OneBits   = 32'h3F80_0000;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_BUILD    = 2'd1,
    MODE_READ_PTR = 2'd2,
    MODE_READ_ENT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_NUM_ROWS  = 2'd0,
    CFG_NUM_COLS  = 2'd1,
    CFG_SYMMETRIC = 2'd2,
    CFG_PATTERN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,
    OP_CLR,
    OP_LD_A,
    OP_LD_B,
    OP_LD_C,
    OP_PS_RD,
    OP_PS_WR,
    OP_SC_RD,
    OP_SC_INS,
    OP_SC_WR,
    OP_RD,
    OP_RESP
  } dp_op_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic [ValW-1:0] value_bits;
    logic [IdxW-1:0] read_index;
  } coo_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] count_or_pointer;
    logic [ColW-1:0] column_out;
    logic [ValW-1:0] value_out;
  } coo_out_t;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } c2c_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic full;
    logic mirror;
    logic rd_bad;
    logic out_free;
  } c2c_stat_t;

endpackage

// ===== hdl/c2c_ctrl.sv =====
// sequencing state machine of the coo to csr converter
module c2c_ctrl import c2c_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MaxRowsDef,
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned IW          = 13,
  parameter int unsigned TW          = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_mode_i,
  output logic          in_ready_o,
  input  c2c_stat_t     stat_i,
  output c2c_cmd_t      cmd_o,
  output logic [IW-1:0] idx_o,
  output logic [TW-1:0] total_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LD_A, S_LD_B, S_LD_C, S_PS_RD, S_PS_WR,
    S_SC_RD, S_SC_INS, S_SC_WR, S_RD, S_RESP
  } state_e;

  state_e        state_q;
  logic [IW-1:0] idx_q;
  logic [TW-1:0] total_q;
  logic          built_q, pend_q;
  status_e       st_q;
  logic          last_row, last_ent;

  assign last_row   = (32'(idx_q) == MAX_ROWS - 1);
  assign last_ent   = (32'(idx_q) + 32'd1 == 32'(total_q));
  assign in_ready_o = (state_q == S_IDLE);
  assign idx_o      = idx_q;
  assign total_o    = total_q;

  always_comb begin
    cmd_o.op = OP_NONE;
    cmd_o.st = st_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o.op = OP_CAP;
      S_CLR:    cmd_o.op = OP_CLR;
      S_LD_A:   if (!stat_i.range_bad && !stat_i.full) cmd_o.op = OP_LD_A;
      S_LD_B:   cmd_o.op = OP_LD_B;
      S_LD_C:   cmd_o.op = OP_LD_C;
      S_PS_RD:  cmd_o.op = OP_PS_RD;
      S_PS_WR:  cmd_o.op = OP_PS_WR;
      S_SC_RD:  cmd_o.op = OP_SC_RD;
      S_SC_INS: cmd_o.op = OP_SC_INS;
      S_SC_WR:  cmd_o.op = OP_SC_WR;
      S_RD:     if (!stat_i.rd_bad) cmd_o.op = OP_RD;
      S_RESP:   if (stat_i.out_free) cmd_o.op = OP_RESP;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      idx_q   <= '0;
      total_q <= '0;
      built_q <= 1'b0;
      pend_q  <= 1'b0;
      st_q    <= ST_OK;
    end else begin
      case (state_q)
        S_CLR: begin
          if (last_row) begin
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= pend_q ? S_LD_A : S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q <= '0;
            st_q  <= ST_OK;
            case (in_mode_i)
              MODE_LOAD: begin
                if (built_q) begin
                  built_q <= 1'b0;
                  total_q <= '0;
                  pend_q  <= 1'b1;
                  state_q <= S_CLR;
                end else begin
                  state_q <= S_LD_A;
                end
              end
              MODE_BUILD: state_q <= S_PS_RD;
              default: begin
                if (built_q) begin
                  state_q <= S_RD;
                end else begin
                  st_q    <= ST_NOT_BUILT;
                  state_q <= S_RESP;
                end
              end
            endcase
          end
        end
        S_LD_A: begin
          if (stat_i.range_bad) begin
            st_q    <= ST_RANGE;
            state_q <= S_RESP;
          end else if (stat_i.full) begin
            st_q    <= ST_FULL;
            state_q <= S_RESP;
          end else begin
            state_q <= S_LD_B;
          end
        end
        S_LD_B: begin
          if (stat_i.mirror) begin
            state_q <= S_LD_C;
          end else begin
            total_q <= total_q + 1'b1;
            state_q <= S_RESP;
          end
        end
        S_LD_C: begin
          total_q <= total_q + TW'(2);
          state_q <= S_RESP;
        end
        S_PS_RD: state_q <= S_PS_WR;
        S_PS_WR: begin
          if (last_row) begin
            idx_q <= '0;
            if (total_q == '0) begin
              built_q <= 1'b1;
              state_q <= S_RESP;
            end else begin
              state_q <= S_SC_RD;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PS_RD;
          end
        end
        S_SC_RD:  state_q <= S_SC_INS;
        S_SC_INS: state_q <= S_SC_WR;
        S_SC_WR: begin
          if (last_ent) begin
            built_q <= 1'b1;
            state_q <= S_RESP;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SC_RD;
          end
        end
        S_RD: begin
          if (stat_i.rd_bad) st_q <= ST_RANGE;
          state_q <= S_RESP;
        end
        S_RESP: if (stat_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/c2c_dp.sv =====
// storage, checks and result register of the coo to csr converter
module c2c_dp import c2c_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MaxRowsDef,
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned IW          = 13,
  parameter int unsigned TW          = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  coo_in_t             in_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  c2c_cmd_t            cmd_i,
  input  logic [IW-1:0]       idx_i,
  input  logic [TW-1:0]       total_i,
  output c2c_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output coo_out_t            out_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [RowW-1:0] num_rows_q;
  logic [ColW-1:0] num_cols_q;
  logic            sym_q, pat_q;
  coo_in_t         req_q;
  logic [TW-1:0]   acc_q;
  logic            out_valid_q;
  coo_out_t        out_q;

  logic [TW-1:0]   cnt_mem [MAX_ROWS];
  logic [TW-1:0]   ptr_mem [MAX_ROWS];
  logic [TW-1:0]   ins_mem [MAX_ROWS];
  logic [RW-1:0]   srow_mem [MAX_ENTRIES];
  logic [ColW-1:0] scol_mem [MAX_ENTRIES];
  logic [ValW-1:0] sval_mem [MAX_ENTRIES];
  logic [ColW-1:0] ccol_mem [MAX_ENTRIES];
  logic [ValW-1:0] cval_mem [MAX_ENTRIES];

  logic [TW-1:0]   cnt_rd_q, ptr_rd_q, ins_rd_q;
  logic [RW-1:0]   srow_rd_q;
  logic [ColW-1:0] scol_rd_q, ccol_rd_q;
  logic [ValW-1:0] sval_rd_q, cval_rd_q;

  logic [31:0]     nrows, r1, c1, ridx;
  logic [RW-1:0]   r0, c0;
  logic [ColW-1:0] c0_col;
  logic [ValW-1:0] val;
  logic            mirror, ptr_top;
  logic            cnt_we;
  logic [RW-1:0]   cnt_wa, cnt_ra;
  logic [TW-1:0]   cnt_wd;
  logic [EW-1:0]   tot_a, tot_b;

  assign nrows  = (32'(num_rows_q) > MAX_ROWS) ? MAX_ROWS : 32'(num_rows_q);
  assign r1     = 32'(req_q.row);
  assign c1     = 32'(req_q.column);
  assign ridx   = 32'(req_q.read_index);
  assign r0     = RW'(r1 - 32'd1);
  assign c0     = RW'(c1 - 32'd1);
  assign c0_col = req_q.column - 1'b1;
  assign val    = pat_q ? OneBits : req_q.value_bits;
  assign mirror = sym_q && (r1 != c1);
  assign ptr_top = (ridx == MAX_ROWS);
  assign tot_a  = EW'(total_i);
  assign tot_b  = EW'(32'(total_i) + 32'd1);

  assign stat_o.mirror    = mirror;
  assign stat_o.range_bad = (r1 == 32'd0) || (r1 > nrows) || (c1 == 32'd0) ||
                            (req_q.column > num_cols_q) || (mirror && (c1 - 32'd1 >= nrows));
  assign stat_o.full      = (32'(total_i) + (mirror ? 32'd2 : 32'd1)) > MAX_ENTRIES;
  assign stat_o.rd_bad    = (req_q.mode == MODE_READ_PTR) ? (ridx > nrows) :
                            ((ridx >= 32'(total_i)) || (ridx >= MAX_ENTRIES));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RowW'(MaxRowsDef);
      num_cols_q <= '1;
      sym_q      <= 1'b0;
      pat_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_ROWS:  num_rows_q <= cfg_data_i[RowW-1:0];
        CFG_NUM_COLS:  num_cols_q <= cfg_data_i[ColW-1:0];
        CFG_SYMMETRIC: sym_q      <= cfg_data_i[0];
        CFG_PATTERN:   pat_q      <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAP) req_q <= in_i;
    if (cmd_i.op == OP_CAP) acc_q <= '0;
    else if (cmd_i.op == OP_PS_WR) acc_q <= acc_q + cnt_rd_q;
  end

  // row count store
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = r0;
    cnt_wd = cnt_rd_q + 1'b1;
    cnt_ra = RW'(idx_i);
    case (cmd_i.op)
      OP_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = RW'(idx_i);
        cnt_wd = '0;
      end
      OP_LD_A: cnt_ra = r0;
      OP_LD_B: begin
        cnt_we = 1'b1;
        cnt_ra = c0;
      end
      OP_LD_C: begin
        cnt_we = 1'b1;
        cnt_wa = c0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // staged entries in load order
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LD_A) begin
      srow_mem[tot_a] <= r0;
      scol_mem[tot_a] <= c0_col;
      sval_mem[tot_a] <= val;
    end else if (cmd_i.op == OP_LD_B && mirror) begin
      srow_mem[tot_b] <= c0;
      scol_mem[tot_b] <= ColW'(r0);
      sval_mem[tot_b] <= val;
    end
    if (cmd_i.op == OP_SC_RD) begin
      srow_rd_q <= srow_mem[EW'(idx_i)];
      scol_rd_q <= scol_mem[EW'(idx_i)];
      sval_rd_q <= sval_mem[EW'(idx_i)];
    end
  end

  // row pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PS_WR) ptr_mem[RW'(idx_i)] <= acc_q;
    if (cmd_i.op == OP_RD) ptr_rd_q <= ptr_mem[RW'(req_q.read_index)];
  end

  // insert positions
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PS_WR) ins_mem[RW'(idx_i)] <= acc_q;
    else if (cmd_i.op == OP_SC_WR) ins_mem[srow_rd_q] <= ins_rd_q + 1'b1;
    if (cmd_i.op == OP_SC_INS) ins_rd_q <= ins_mem[srow_rd_q];
  end

  // csr entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SC_WR) begin
      ccol_mem[EW'(ins_rd_q)] <= scol_rd_q;
      cval_mem[EW'(ins_rd_q)] <= sval_rd_q;
    end
    if (cmd_i.op == OP_RD) begin
      ccol_rd_q <= ccol_mem[EW'(req_q.read_index)];
      cval_rd_q <= cval_mem[EW'(req_q.read_index)];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESP) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESP) begin
      out_q.status           <= cmd_i.st;
      out_q.count_or_pointer <= '0;
      out_q.column_out       <= '0;
      out_q.value_out        <= '0;
      case (req_q.mode)
        MODE_LOAD, MODE_BUILD: out_q.count_or_pointer <= IdxW'(total_i);
        MODE_READ_PTR: begin
          if (cmd_i.st == ST_OK) begin
            out_q.count_or_pointer <= ptr_top ? IdxW'(total_i) : IdxW'(ptr_rd_q);
          end
        end
        MODE_READ_ENT: begin
          if (cmd_i.st == ST_OK) begin
            out_q.column_out <= ccol_rd_q;
            out_q.value_out  <= cval_rd_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/coo_to_csr_converter_unit.sv =====
// top level of the coo to csr converter
// Takes one request at a time; the result register lets the next request be taken while a
// result waits. A load checks the request, then does the row-count read-modify-write and the
// staged writes, with a second count update when mirrored; a rejected load ends at its result.
// A read fetches the pointer or entry first (not before the first build), and a build runs a
// prefix sum over the row-count memory, then a scatter that places each stored entry. After
// reset and before the first load after a build, a clearing pass over all MAX_ROWS rows zeroes
// the row counts while no request is taken; configuration writes are taken at any time.
module coo_to_csr_converter_unit import c2c_pkg::*; #(
  parameter int unsigned MAX_ROWS    = MaxRowsDef,
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  coo_in_t             in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output coo_out_t            out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned IW = (RW > EW) ? RW : EW;
  localparam int unsigned TW = $clog2(MAX_ENTRIES + 1);

  c2c_cmd_t      cmd;
  c2c_stat_t     stat;
  logic [IW-1:0] idx;
  logic [TW-1:0] total;

  assign cfg_ready_o = 1'b1;

  c2c_ctrl #(
    .MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES), .IW(IW), .TW(TW)
  ) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_mode_i(in_i.mode), .in_ready_o,
    .stat_i(stat), .cmd_o(cmd), .idx_o(idx), .total_o(total)
  );

  c2c_dp #(
    .MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES), .IW(IW), .TW(TW)
  ) u_dp (
    .clk_i, .rst_ni, .in_i, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cmd_i(cmd), .idx_i(idx), .total_i(total), .stat_o(stat),
    .out_valid_o, .out_ready_i, .out_o
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while another is in work");

  a_resp_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_RESP) |=> out_valid_o)
    else $error("result not presented");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total) <= MAX_ENTRIES)
    else $error("entry total above capacity");

endmodule
